/* hw/rtl/rgbcf_pkg.sv */
// Shared types and constants for the RGB convolution filter.
package rgbcf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int BLUR_SIZE = 5;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = COL_W + 1;
  localparam int LAG_W = WIDTH_W + 1;
  localparam int ROW_W = 16;
  localparam int BANKS = 4;
  localparam int BANK_W = 2;
  localparam int CH_W = 8;
  localparam int N_CH = 3;
  localparam int PIX_W = CH_W * N_CH;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_WIDTH_BITS = 11;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Blur sum peaks at 27 * 255; divide by 27 as multiply by ceil(2^18 / 27)
  localparam int BLUR_SUM_W = 13;
  localparam int DIV27_W = 14;
  localparam logic [DIV27_W-1:0] DIV27_MULT = 14'd9710;
  localparam int DIV27_SHIFT = 18;
  localparam int SHARP_POS_W = 11;
  localparam int SHARP_NEG_W = 10;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic MODE_BLUR = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  localparam logic [CFG_WIDTH_BITS-1:0] RST_WIDTH = 11'd640;
  localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd480;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic mode;
    logic frame_end;
  } ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [COL_W-1:0]  col;
    logic [BANK_W-1:0] bank;
    ctrl_t             ctrl;
  } op_t;

endpackage

/* hw/rtl/rgbcf_queue.sv */
// Short op queue between the classifying front and the filter back end.
module rgbcf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rgbcf_pkg::op_t    push_op,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output rgbcf_pkg::op_t    head_op
);

  localparam int QPTR_W = rgbcf_pkg::QPTR_W;
  localparam int QCNT_W = rgbcf_pkg::QCNT_W;

  rgbcf_pkg::op_t q_mem_r [rgbcf_pkg::QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full = cnt_r == QCNT_W'(rgbcf_pkg::QDEPTH);
  assign empty = cnt_r == '0;
  assign head_op = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10: cnt_r <= cnt_r + QCNT_W'(1);
        2'b01: cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(rgbcf_pkg::QDEPTH))
    else $error("op queue count out of range");
`endif

endmodule

/* hw/rtl/rgbcf_front.sv */
// Front end: config registers, frame counters and op classification.
module rgbcf_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rgbcf_pkg::in_item_t                  in_data,
  input  logic                                 cfg_we,
  input  logic [rgbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbcf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 q_full,
  output logic                                 push,
  output rgbcf_pkg::op_t                       push_op
);

  localparam int COL_W = rgbcf_pkg::COL_W;
  localparam int WIDTH_W = rgbcf_pkg::WIDTH_W;
  localparam int LAG_W = rgbcf_pkg::LAG_W;
  localparam int ROW_W = rgbcf_pkg::ROW_W;
  localparam int ROWX_W = ROW_W + 1;
  localparam int BANK_W = rgbcf_pkg::BANK_W;
  localparam int CFGW_W = rgbcf_pkg::CFG_WIDTH_BITS;

  logic              mode_cfg_r;
  logic [CFGW_W-1:0] width_cfg_r;
  logic [ROW_W-1:0]  height_cfg_r;

  logic              act_mode_r, act_mode_nxt;
  logic [WIDTH_W-1:0] act_w_r, act_w_nxt;
  logic [ROW_W-1:0]  act_h_r, act_h_nxt;
  logic [LAG_W-1:0]  lag_r, lag_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              done_r, done_nxt;

  logic              is_pix, ignore, clr, latch, emit, interior, frame_last;
  logic [COL_W-1:0]  ic, oc;
  logic [ROW_W-1:0]  ir, orow, ir_inc, orow_inc;
  logic [WIDTH_W-1:0] w_cl, w_eff, ic_inc, oc_inc;
  logic [ROW_W-1:0]  h_cl, h_eff;
  logic [LAG_W-1:0]  lag_new, lag_eff;
  logic              mode_eff, in_wrap, out_wrap;
  logic [1:0]        rad;

  always_comb begin
    in_ready = !q_full;
    is_pix = in_data.command == rgbcf_pkg::CMD_PIXEL;
    ignore = !is_pix && !done_r;
    push = in_valid && !q_full && !ignore;

    // A pixel after the last one of a frame starts over
    clr = is_pix && done_r;
    ic = clr ? '0 : in_col_r;
    ir = clr ? '0 : in_row_r;
    oc = clr ? '0 : out_col_r;
    orow = clr ? '0 : out_row_r;
    latch = is_pix && (ic == '0) && (ir == '0);

    if (width_cfg_r == '0) begin
      w_cl = WIDTH_W'(1);
    end else if (32'(width_cfg_r) > rgbcf_pkg::MAX_WIDTH) begin
      w_cl = WIDTH_W'(rgbcf_pkg::MAX_WIDTH);
    end else begin
      w_cl = WIDTH_W'(width_cfg_r);
    end
    h_cl = (height_cfg_r == '0) ? ROW_W'(1) : height_cfg_r;
    if (mode_cfg_r == rgbcf_pkg::MODE_SHARPEN) begin
      lag_new = LAG_W'(w_cl) + LAG_W'(1);
    end else begin
      lag_new = {w_cl, 1'b0} + LAG_W'(2);
    end

    mode_eff = latch ? mode_cfg_r : act_mode_r;
    w_eff = latch ? w_cl : act_w_r;
    h_eff = latch ? h_cl : act_h_r;
    lag_eff = latch ? lag_new : lag_r;
    emit = lag_eff == '0;
    rad = (mode_eff == rgbcf_pkg::MODE_SHARPEN) ? 2'd1 : 2'd2;

    ic_inc = {1'b0, ic} + WIDTH_W'(1);
    in_wrap = ic_inc >= w_eff;
    ir_inc = ir + ROW_W'(1);
    oc_inc = {1'b0, oc} + WIDTH_W'(1);
    out_wrap = oc_inc >= w_eff;
    orow_inc = orow + ROW_W'(1);

    interior = ({1'b0, oc} >= WIDTH_W'(rad)) &&
               ({1'b0, oc} + WIDTH_W'(rad) < w_eff) &&
               (orow >= ROW_W'(rad)) &&
               ({1'b0, orow} + ROWX_W'(rad) < {1'b0, h_eff});
    frame_last = emit && out_wrap && (orow_inc >= h_eff);

    push_op.pix = is_pix ? {in_data.red_in, in_data.green_in, in_data.blue_in} : '0;
    push_op.col = ic;
    push_op.bank = ir[BANK_W-1:0];
    push_op.ctrl.emit = emit;
    push_op.ctrl.interior = interior;
    push_op.ctrl.mode = mode_eff;
    push_op.ctrl.frame_end = frame_last;

    act_mode_nxt = act_mode_r;
    act_w_nxt = act_w_r;
    act_h_nxt = act_h_r;
    lag_nxt = lag_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    done_nxt = done_r;
    if (push) begin
      act_mode_nxt = mode_eff;
      act_w_nxt = w_eff;
      act_h_nxt = h_eff;
      lag_nxt = emit ? '0 : lag_eff - LAG_W'(1);
      in_col_nxt = in_wrap ? '0 : ic_inc[COL_W-1:0];
      in_row_nxt = in_wrap ? ir_inc : ir;
      done_nxt = (done_r && !clr) || (is_pix && in_wrap && (ir_inc >= h_eff));
      out_col_nxt = oc;
      out_row_nxt = orow;
      if (emit) begin
        out_col_nxt = out_wrap ? '0 : oc_inc[COL_W-1:0];
        out_row_nxt = out_wrap ? orow_inc : orow;
      end
      // Last result of the frame: drop back to idle
      if (frame_last) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r <= rgbcf_pkg::MODE_BLUR;
      width_cfg_r <= rgbcf_pkg::RST_WIDTH;
      height_cfg_r <= rgbcf_pkg::RST_HEIGHT;
      act_mode_r <= rgbcf_pkg::MODE_BLUR;
      act_w_r <= WIDTH_W'(rgbcf_pkg::RST_WIDTH);
      act_h_r <= rgbcf_pkg::RST_HEIGHT;
      lag_r <= '0;
      in_col_r <= '0;
      in_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rgbcf_pkg::CFG_MODE: mode_cfg_r <= cfg_data[0];
          rgbcf_pkg::CFG_WIDTH: width_cfg_r <= cfg_data[CFGW_W-1:0];
          rgbcf_pkg::CFG_HEIGHT: height_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      act_mode_r <= act_mode_nxt;
      act_w_r <= act_w_nxt;
      act_h_r <= act_h_nxt;
      lag_r <= lag_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      done_r <= done_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_op.ctrl.frame_end |=>
      (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && !done_r)
    else $error("counters not cleared after frame end");
  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> (in_row_r < act_h_r) && (out_row_r < act_h_r))
    else $error("row counter past frame height");
`endif

endmodule

/* hw/rtl/rgbcf_linebuf.sv */
// Four-row line store, one bank per row, read and written once per op.
module rgbcf_linebuf (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rgbcf_pkg::COL_W-1:0]      col,
  input  logic [rgbcf_pkg::BANK_W-1:0]     wr_bank,
  input  logic [rgbcf_pkg::PIX_W-1:0]      wr_data,
  output logic [rgbcf_pkg::PIX_W-1:0]      rd_data [rgbcf_pkg::BANKS]
);

  localparam int BANK_W = rgbcf_pkg::BANK_W;

  for (genvar b = 0; b < rgbcf_pkg::BANKS; b++) begin : g_bank
    logic [rgbcf_pkg::PIX_W-1:0] bank_mem [rgbcf_pkg::MAX_WIDTH];
    logic [rgbcf_pkg::PIX_W-1:0] bank_rd_r;

    // Read returns the old entry when the same op overwrites it
    always_ff @(posedge clk) begin
      if (en) begin
        if (wr_bank == BANK_W'(b)) begin
          bank_mem[col] <= wr_data;
        end
        bank_rd_r <= bank_mem[col];
      end
    end

    assign rd_data[b] = bank_rd_r;
  end

endmodule

/* hw/rtl/rgbcf_back.sv */
// Back end: line store, 5x5 window, kernel arithmetic and output register.
module rgbcf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rgbcf_pkg::op_t          head_op,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgbcf_pkg::out_item_t    out_data
);

  localparam int WIN = rgbcf_pkg::BLUR_SIZE;
  localparam int CH_W = rgbcf_pkg::CH_W;
  localparam int N_CH = rgbcf_pkg::N_CH;
  localparam int PIX_W = rgbcf_pkg::PIX_W;
  localparam int BANKS = rgbcf_pkg::BANKS;
  localparam int BANK_W = rgbcf_pkg::BANK_W;
  localparam int SUM_W = rgbcf_pkg::BLUR_SUM_W;
  localparam int PROD_W = SUM_W + rgbcf_pkg::DIV27_W;
  localparam int QUO_W = PROD_W - rgbcf_pkg::DIV27_SHIFT;
  localparam int POS_W = rgbcf_pkg::SHARP_POS_W;
  localparam int NEG_W = rgbcf_pkg::SHARP_NEG_W;

  logic adv;
  logic [PIX_W-1:0] rd_data [BANKS];
  logic [PIX_W-1:0] col_px [WIN];

  logic             s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  rgbcf_pkg::op_t   s1_op_r;
  rgbcf_pkg::ctrl_t s2_ctrl_r, s3_ctrl_r;
  logic [PIX_W-1:0] win_r [WIN][WIN];

  logic [CH_W-1:0]  wc [N_CH][WIN][WIN];
  logic [SUM_W-1:0] near_sum [N_CH];
  logic [SUM_W-1:0] ring_sum [N_CH];
  logic [SUM_W-1:0] blur_sum [N_CH];
  logic [POS_W-1:0] sh_pos [N_CH];
  logic [NEG_W-1:0] sh_neg [N_CH];
  logic [POS_W-1:0] sh_diff [N_CH];
  logic [CH_W-1:0]  sharp_px [N_CH];
  logic [PIX_W-1:0] center;

  logic [SUM_W-1:0] s3_blur_r [N_CH];
  logic [CH_W-1:0]  s3_sharp_r [N_CH];
  logic [PIX_W-1:0] s3_center_r;

  logic [PROD_W-1:0] prod [N_CH];
  logic [QUO_W-1:0]  quo [N_CH];
  logic [CH_W-1:0]   res [N_CH];
  rgbcf_pkg::out_item_t out_data_r, out_nxt;

  // Whole back end moves together; it stalls only on a held result
  assign adv = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  rgbcf_linebuf u_linebuf (
    .clk     (clk),
    .en      (q_pop),
    .col     (head_op.col),
    .wr_bank (head_op.bank),
    .wr_data (head_op.pix),
    .rd_data (rd_data)
  );

  // New column: the four stored rows oldest first, then the incoming pixel
  always_comb begin
    for (int k = 0; k < BANKS; k++) begin
      col_px[k] = rd_data[BANK_W'(s1_op_r.bank + BANK_W'(k))];
    end
    col_px[WIN-1] = s1_op_r.pix;
  end

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          wc[c][i][j] = win_r[i][j][c*CH_W +: CH_W];
        end
      end
    end
    for (int c = 0; c < N_CH; c++) begin
      near_sum[c] = SUM_W'(wc[c][1][2]) + SUM_W'(wc[c][2][1]) +
                    SUM_W'(wc[c][2][3]) + SUM_W'(wc[c][3][2]);
      ring_sum[c] = SUM_W'(wc[c][0][2]) + SUM_W'(wc[c][1][1]) +
                    SUM_W'(wc[c][1][3]) + SUM_W'(wc[c][2][0]) +
                    SUM_W'(wc[c][2][4]) + SUM_W'(wc[c][3][1]) +
                    SUM_W'(wc[c][3][3]) + SUM_W'(wc[c][4][2]);
      blur_sum[c] = SUM_W'(wc[c][2][2]) * SUM_W'(7) + near_sum[c] * SUM_W'(3) +
                    ring_sum[c];
      sh_pos[c] = POS_W'(wc[c][3][3]) * POS_W'(5);
      sh_neg[c] = NEG_W'(wc[c][2][3]) + NEG_W'(wc[c][4][3]) +
                  NEG_W'(wc[c][3][2]) + NEG_W'(wc[c][3][4]);
      sh_diff[c] = sh_pos[c] - POS_W'(sh_neg[c]);
      if (POS_W'(sh_neg[c]) >= sh_pos[c]) begin
        sharp_px[c] = '0;
      end else if (sh_diff[c] > POS_W'(rgbcf_pkg::CH_MAX)) begin
        sharp_px[c] = rgbcf_pkg::CH_MAX;
      end else begin
        sharp_px[c] = sh_diff[c][CH_W-1:0];
      end
    end
    center = (s2_ctrl_r.mode == rgbcf_pkg::MODE_SHARPEN) ? win_r[3][3] : win_r[2][2];
  end

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      prod[c] = PROD_W'(s3_blur_r[c]) * PROD_W'(rgbcf_pkg::DIV27_MULT);
      quo[c] = prod[c][rgbcf_pkg::DIV27_SHIFT +: QUO_W];
      if (!s3_ctrl_r.interior) begin
        res[c] = s3_center_r[c*CH_W +: CH_W];
      end else if (s3_ctrl_r.mode == rgbcf_pkg::MODE_SHARPEN) begin
        res[c] = s3_sharp_r[c];
      end else if (quo[c] > QUO_W'(rgbcf_pkg::CH_MAX)) begin
        res[c] = rgbcf_pkg::CH_MAX;
      end else begin
        res[c] = quo[c][CH_W-1:0];
      end
    end
    out_nxt.red_out = res[2];
    out_nxt.green_out = res[1];
    out_nxt.blue_out = res[0];
    out_nxt.frame_end = s3_ctrl_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_pop;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      out_valid_r <= s3_valid_r && s3_ctrl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= head_op;
      s2_ctrl_r <= s1_op_r.ctrl;
      if (s1_valid_r) begin
        for (int i = 0; i < WIN; i++) begin
          for (int j = 0; j < WIN - 1; j++) begin
            win_r[i][j] <= win_r[i][j+1];
          end
          win_r[i][WIN-1] <= col_px[i];
        end
      end
      s3_ctrl_r <= s2_ctrl_r;
      s3_center_r <= center;
      for (int c = 0; c < N_CH; c++) begin
        s3_blur_r[c] <= blur_sum[c];
        s3_sharp_r[c] <= sharp_px[c];
      end
      out_data_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !q_pop)
    else $error("queue popped while result is held");
`endif

endmodule

/* hw/rtl/rgb_image_convolution_filter_top.sv */
// rgb_image_convolution_filter_top: 5x5 blur / 3x3 sharpen over a raster RGB pixel stream.
// Throughput: one item per clock; in_ready drops only while the 4-entry op queue is full.
// A result passes the op queue, s1 (line store read), s2 (window), s3 and output register
//   after the item that releases it, which comes 2*width+2 (blur) or width+1 (sharpen) items
//   after its pixel; one line store column read per item (all four banks) sets the rate.
// Reset (rst_n low, synchronous): counters, queue, pipeline and registers to defaults.
module rgb_image_convolution_filter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rgbcf_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rgbcf_pkg::out_item_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [rgbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  rgbcf_pkg::op_t push_op;
  rgbcf_pkg::op_t head_op;

  rgbcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  rgbcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head_op (head_op)
  );

  rgbcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
